/* hdl/sps_pkg.sv */
// ---------------------------------------------------------------------------
// sps_pkg
// Types, constants and the pattern step table of the servo pattern sequencer.
// ---------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned RomAddrW    = 5;
  localparam int unsigned MaxPatLen   = 9;
  localparam int unsigned PitchLimit  = 900;

  localparam logic [3:0]  MODE_IDLE     = 4'd0;
  localparam logic [3:0]  MODE_LAST_PAT = 4'd4;

  localparam logic [9:0]  PITCH_BASELINE_RST = 10'd600;
  localparam logic [15:0] TRACK_INTERVAL_RST = 16'd100;
  localparam logic [9:0]  TRACK_DEADBAND_RST = 10'd20;
  localparam logic [9:0]  TRACK_PACE_RST     = 10'd200;
  localparam logic [3:0]  FREE_MODE_RST      = 4'd5;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_SPIN = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PITCH_BASELINE = 3'd0,
    CFG_TRACK_INTERVAL = 3'd1,
    CFG_TRACK_DEADBAND = 3'd2,
    CFG_TRACK_PACE     = 3'd3,
    CFG_FREE_MODE      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [8:0]  dy;
    logic [9:0]         pace;
    logic [15:0]        dwell;
    logic               spin;
  } rom_step_t;

  function automatic rom_step_t rom_step(input logic [RomAddrW-1:0] addr);
    rom_step_t s;
    s = '0;
    unique case (addr)
      5'd0:  s = '{12'sd0,    9'sd0,   10'd250, 16'd60000, 1'b0};
      5'd1:  s = '{12'sd500,  9'sd180, 10'd250, 16'd3500,  1'b0};
      5'd2:  s = '{12'sd0,    9'sd200, 10'd200, 16'd1500,  1'b0};
      5'd3:  s = '{-12'sd500, 9'sd180, 10'd250, 16'd3500,  1'b0};
      5'd4:  s = '{12'sd0,    9'sd200, 10'd200, 16'd1500,  1'b0};
      5'd5:  s = '{12'sd400,  9'sd0,   10'd0,   16'd1000,  1'b1};
      5'd6:  s = '{12'sd0,    9'sd0,   10'd0,   16'd200,   1'b0};
      5'd7:  s = '{-12'sd400, 9'sd0,   10'd0,   16'd1000,  1'b1};
      5'd8:  s = '{12'sd0,    9'sd0,   10'd0,   16'd200,   1'b0};
      5'd9:  s = '{12'sd0,    9'sd150, 10'd300, 16'd350,   1'b0};
      5'd10: s = '{12'sd0,    -9'sd20, 10'd300, 16'd350,   1'b0};
      5'd11: s = '{12'sd0,    9'sd150, 10'd300, 16'd350,   1'b0};
      5'd12: s = '{12'sd0,    -9'sd20, 10'd300, 16'd350,   1'b0};
      5'd13: s = '{12'sd0,    9'sd0,   10'd250, 16'd600,   1'b0};
      5'd14: s = '{12'sd300,  9'sd30,  10'd600, 16'd180,   1'b0};
      5'd15: s = '{-12'sd300, 9'sd30,  10'd600, 16'd180,   1'b0};
      5'd16: s = '{12'sd300,  9'sd30,  10'd600, 16'd180,   1'b0};
      5'd17: s = '{-12'sd300, 9'sd30,  10'd600, 16'd180,   1'b0};
      5'd18: s = '{12'sd300,  9'sd30,  10'd600, 16'd180,   1'b0};
      5'd19: s = '{-12'sd300, 9'sd30,  10'd600, 16'd180,   1'b0};
      5'd20: s = '{12'sd0,    9'sd0,   10'd400, 16'd800,   1'b0};
      5'd21: s = '{12'sd80,   9'sd0,   10'd250, 16'd500,   1'b0};
      5'd22: s = '{-12'sd80,  9'sd0,   10'd250, 16'd500,   1'b0};
      5'd23: s = '{12'sd80,   9'sd0,   10'd250, 16'd500,   1'b0};
      5'd24: s = '{-12'sd80,  9'sd0,   10'd250, 16'd500,   1'b0};
      5'd25: s = '{12'sd0,    9'sd50,  10'd220, 16'd400,   1'b0};
      5'd26: s = '{12'sd0,    9'sd0,   10'd220, 16'd600,   1'b0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [RomAddrW-1:0] pat_offset(input logic [2:0] pat);
    logic [RomAddrW-1:0] o;
    unique case (pat)
      3'd1:    o = 5'd1;
      3'd2:    o = 5'd5;
      3'd3:    o = 5'd14;
      3'd4:    o = 5'd21;
      default: o = 5'd0;
    endcase
    return o;
  endfunction

  function automatic logic [3:0] pat_length(input logic [2:0] pat);
    logic [3:0] l;
    unique case (pat)
      3'd1:    l = 4'd4;
      3'd2:    l = 4'd9;
      3'd3:    l = 4'd7;
      3'd4:    l = 4'd6;
      default: l = 4'd1;
    endcase
    return l;
  endfunction

endpackage

/* hdl/servo_pattern_sequencer_top.sv */
// ---------------------------------------------------------------------------
// servo_pattern_sequencer_top
// Turns agent ticks into servo move and spin requests.
// ---------------------------------------------------------------------------
// Each request on s_axis is one tick (time, mode, tracking flag, target). It
// yields zero or one servo request on m_axis: a tracking move, a pattern move
// or a spin, with m_axis_tuser telling move from spin.
// An accepted tick is registered in the compute stage, and its request in
// the output register when that stage advances. One tick per cycle is taken
// back to back while m_axis does not stall. The sequencer state sits in a
// one-entry synchronous memory read on accept and written back when the
// compute stage advances; a bypass register covers a tick that follows its
// predecessor directly, so the rate is set by that read-modify-write loop at
// one tick per cycle. A stalled m_axis holds the output register; one more
// tick is then taken into the compute stage before s_axis_tready drops.
// Reset restores the register defaults and the initial state (idle mode,
// tracking off, timers clear); the memory needs no clearing pass, since a
// flag marks it empty until its first write. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i by the user only while idle; not enforced.
// ---------------------------------------------------------------------------
module servo_pattern_sequencer_top #(
  parameter int unsigned MAX_STEPS = 16,
  parameter int unsigned NUM_MODES = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sps_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // now_ms[31:0], agent_mode[35:32], tracking_on[36], target_yaw[48:37],
  // target_pitch[58:49], zero fill[63:59]
  input  logic [63:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // yaw_or_velocity[11:0], pitch_out[21:12], pace_out[31:22]
  output logic [31:0]                  m_axis_tdata,
  // command_kind[0]
  output logic                         m_axis_tuser
);
  import sps_pkg::*;

  localparam int unsigned StepLim = (MAX_STEPS < MaxPatLen) ? MAX_STEPS : MaxPatLen;
  localparam int unsigned SidxW   = $clog2(StepLim + 1);

  typedef struct packed {
    logic [3:0]        mode;
    logic              trk;
    logic [SidxW-1:0]  step;
    logic [31:0]       lt;
    logic              ltv;
    logic signed [11:0] iyaw;
    logic [9:0]        ipitch;
    logic              iv;
  } state_t;

  localparam state_t StRst = '0;

  // configuration
  logic [9:0]  pitch_base_q;
  logic [15:0] interval_q;
  logic [9:0]  deadband_q;
  logic [9:0]  pace_q;
  logic [3:0]  free_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_base_q <= PITCH_BASELINE_RST;
      interval_q   <= TRACK_INTERVAL_RST;
      deadband_q   <= TRACK_DEADBAND_RST;
      pace_q       <= TRACK_PACE_RST;
      free_mode_q  <= FREE_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PITCH_BASELINE: pitch_base_q <= cfg_wdata_i[9:0];
        CFG_TRACK_INTERVAL: interval_q   <= cfg_wdata_i;
        CFG_TRACK_DEADBAND: deadband_q   <= cfg_wdata_i[9:0];
        CFG_TRACK_PACE:     pace_q       <= cfg_wdata_i[9:0];
        CFG_FREE_MODE:      free_mode_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // compute stage payload
  logic [31:0]        now_q;
  logic [3:0]         mode_q;
  logic               trk_q;
  logic signed [11:0] tyaw_q;
  logic [9:0]         tpitch_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= s_axis_tdata[31:0];
      mode_q   <= s_axis_tdata[35:32];
      trk_q    <= s_axis_tdata[36];
      tyaw_q   <= s_axis_tdata[48:37];
      tpitch_q <= s_axis_tdata[58:49];
    end
  end

  // state memory with bypass
  state_t mem_q [1];
  state_t rd_q, wb_q, st, nx;
  logic   fwd_q, written_q, mem_ok_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[0] <= nx;
      wb_q     <= nx;
    end
    if (in_acc) begin
      rd_q <= mem_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      written_q  <= 1'b0;
      mem_ok_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv;
        mem_ok_q   <= written_q;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        written_q <= 1'b1;
      end
    end
  end

  assign st = fwd_q ? wb_q : (mem_ok_q ? rd_q : StRst);

  // command logic
  logic               mode_chg, trk_chg, trk_path, moved, emit;
  logic [SidxW-1:0]   step_a;
  logic               ltv_a, iv_a;
  logic [31:0]        elapsed;
  logic signed [12:0] dyaw;
  logic signed [10:0] dpitch;
  logic [12:0]        ayaw;
  logic [10:0]        apitch;
  logic [2:0]         pat;
  rom_step_t          rs;
  logic signed [11:0] psum;
  logic               kind;
  logic signed [11:0] yv;
  logic [9:0]         pitch_o, pace_o;

  always_comb begin
    mode_chg = mode_q != st.mode;
    trk_chg  = trk_q != st.trk;
    step_a   = (mode_chg || trk_chg) ? '0 : st.step;
    ltv_a    = st.ltv && !mode_chg && !trk_chg;
    iv_a     = st.iv && !trk_chg;
    elapsed  = now_q - st.lt;
    trk_path = trk_q && (mode_q == MODE_IDLE || mode_q == free_mode_q);

    dyaw   = 13'(tyaw_q) - 13'(st.iyaw);
    ayaw   = dyaw[12] ? 13'(-dyaw) : 13'(dyaw);
    dpitch = $signed({1'b0, tpitch_q}) - $signed({1'b0, st.ipitch});
    apitch = dpitch[10] ? 11'(-dpitch) : 11'(dpitch);
    moved  = !iv_a || ayaw >= {3'b0, deadband_q} || apitch >= {1'b0, deadband_q};

    pat  = (mode_q <= MODE_LAST_PAT) ? mode_q[2:0] : 3'd0;
    rs   = rom_step(pat_offset(pat) + RomAddrW'(step_a));
    psum = $signed({2'b0, pitch_base_q}) + 12'(rs.dy);

    nx      = '{mode_q, trk_q, step_a, st.lt, ltv_a, st.iyaw, st.ipitch, iv_a};
    emit    = 1'b0;
    kind    = CMD_MOVE;
    yv      = tyaw_q;
    pitch_o = tpitch_q;
    pace_o  = pace_q;

    if (trk_path) begin
      if (!(ltv_a && elapsed < {16'b0, interval_q}) && moved) begin
        emit      = 1'b1;
        nx.iyaw   = tyaw_q;
        nx.ipitch = tpitch_q;
        nx.iv     = 1'b1;
        nx.lt     = now_q;
        nx.ltv    = 1'b1;
      end
    end else if (5'(mode_q) < 5'(NUM_MODES)) begin
      if (SidxW'(4'(step_a) >= pat_length(pat) ? 1 : 0) != '0
          || 7'(step_a) >= 7'(MAX_STEPS)) begin
        nx.step = '0;
        nx.ltv  = 1'b0;
      end else if (!(ltv_a && elapsed < {16'b0, rs.dwell})) begin
        emit   = 1'b1;
        yv     = rs.x;
        nx.lt  = now_q;
        nx.ltv = 1'b1;
        nx.step = step_a + 1'b1;
        if (rs.spin) begin
          kind    = CMD_SPIN;
          pitch_o = '0;
          pace_o  = '0;
        end else begin
          kind   = CMD_MOVE;
          pace_o = rs.pace;
          priority if (psum < 0) begin
            pitch_o = '0;
          end else if (psum > 12'(PitchLimit)) begin
            pitch_o = 10'(PitchLimit);
          end else begin
            pitch_o = psum[9:0];
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [31:0] out_data_q;
  logic        out_kind_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_data_q <= {pace_o, pitch_o, yv};
      out_kind_q <= kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

/* tb/sv/servo_pattern_sequencer_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// servo_pattern_sequencer_top_tb
// Self-checking bench for the servo pattern sequencer.
// A driver feeds tick requests from a backlog queue with random gaps, a
// monitor takes servo requests with random stalls. Every accepted tick runs
// through a behavioral copy of the sequencer, and each servo request out of
// the block is compared field by field with the oldest predicted one.
// Phases run with reset values, extreme and random register settings.
// ---------------------------------------------------------------------------
module servo_pattern_sequencer_top_tb;
  import sps_pkg::*;

  localparam int unsigned MAX_STEPS  = 16;
  localparam int unsigned NUM_MODES  = 10;
  localparam int          PITCH_CEIL = 900;

  localparam logic [3:0] MODE_THINKING  = 4'd1;
  localparam logic [3:0] MODE_REPLYING  = 4'd2;
  localparam logic [3:0] MODE_ERROR     = 4'd3;
  localparam logic [3:0] MODE_REMINDER  = 4'd4;
  localparam logic [3:0] MODE_OTHER     = 4'd7;
  localparam logic [3:0] MODE_OTHER_TOP = 4'd9;
  localparam logic [3:0] MODE_NO_PAT    = 4'd10;
  localparam logic [3:0] MODE_BEYOND    = 4'd15;

  typedef struct packed {
    logic [9:0]         pitch;
    logic signed [11:0] yaw;
    logic               trk;
    logic [3:0]         mode;
    logic [31:0]        now_ms;
  } tick_t;

  typedef struct packed {
    logic               kind;
    logic [9:0]         pace;
    logic [9:0]         pitch;
    logic signed [11:0] yv;
  } servo_req_t;

  typedef struct packed {
    int x;
    int dy;
    int pace;
    int dwell;
    bit spin;
  } pose_step_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tuser;

  servo_pattern_sequencer_top #(
    .MAX_STEPS(MAX_STEPS),
    .NUM_MODES(NUM_MODES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Register copies
  logic [9:0]  cfg_baseline  = 10'd600;
  logic [15:0] cfg_interval  = 16'd100;
  logic [9:0]  cfg_deadband  = 10'd20;
  logic [9:0]  cfg_pace      = 10'd200;
  logic [3:0]  cfg_free_code = 4'd5;

  // Sequencer state copies
  logic [3:0]  seq_mode     = MODE_IDLE;
  logic        seq_tracking = 1'b0;
  logic [5:0]  seq_step     = '0;
  logic [31:0] timer_ms     = '0;
  logic        timer_valid  = 1'b0;
  int          aim_yaw      = 0;
  int          aim_pitch    = 0;
  logic        aim_valid    = 1'b0;

  tick_t      tick_backlog[$];
  servo_req_t servo_due[$];
  tick_t      tick_on_bus;
  servo_req_t want;
  servo_req_t got;
  int         src_gap     = 0;
  int         sink_gap    = 0;
  bit         src_steady  = 1'b0;
  bit         sink_steady = 1'b0;
  int         mismatches  = 0;

  logic [31:0] gen_now   = '0;
  logic [3:0]  gen_mode  = MODE_IDLE;
  logic        gen_trk   = 1'b0;
  int          gen_yaw   = 0;
  int          gen_pitch = 0;

  function automatic pose_step_t pattern_step(input int addr);
    pose_step_t s;
    s = '0;
    case (addr)
      0:  s = '{0,    0,   250, 60000, 0};
      1:  s = '{500,  180, 250, 3500,  0};
      2:  s = '{0,    200, 200, 1500,  0};
      3:  s = '{-500, 180, 250, 3500,  0};
      4:  s = '{0,    200, 200, 1500,  0};
      5:  s = '{400,  0,   0,   1000,  1};
      6:  s = '{0,    0,   0,   200,   0};
      7:  s = '{-400, 0,   0,   1000,  1};
      8:  s = '{0,    0,   0,   200,   0};
      9:  s = '{0,    150, 300, 350,   0};
      10: s = '{0,    -20, 300, 350,   0};
      11: s = '{0,    150, 300, 350,   0};
      12: s = '{0,    -20, 300, 350,   0};
      13: s = '{0,    0,   250, 600,   0};
      14: s = '{300,  30,  600, 180,   0};
      15: s = '{-300, 30,  600, 180,   0};
      16: s = '{300,  30,  600, 180,   0};
      17: s = '{-300, 30,  600, 180,   0};
      18: s = '{300,  30,  600, 180,   0};
      19: s = '{-300, 30,  600, 180,   0};
      20: s = '{0,    0,   400, 800,   0};
      21: s = '{80,   0,   250, 500,   0};
      22: s = '{-80,  0,   250, 500,   0};
      23: s = '{80,   0,   250, 500,   0};
      24: s = '{-80,  0,   250, 500,   0};
      25: s = '{0,    50,  220, 400,   0};
      26: s = '{0,    0,   220, 600,   0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic void compute_servo_request(input tick_t tk);
    servo_req_t req;
    pose_step_t st;
    logic [3:0] pat;
    logic [31:0] elapsed;
    int yaw, pitch, dyaw, dpitch, p, ofs, len;
    yaw   = $signed(tk.yaw);
    pitch = tk.pitch;
    if (tk.mode != seq_mode) begin
      seq_mode    = tk.mode;
      seq_step    = '0;
      timer_valid = 1'b0;
    end
    if (tk.trk != seq_tracking) begin
      seq_tracking = tk.trk;
      aim_valid    = 1'b0;
      seq_step     = '0;
      timer_valid  = 1'b0;
    end
    elapsed = tk.now_ms - timer_ms;
    if (seq_tracking && (seq_mode == MODE_IDLE || seq_mode == cfg_free_code)) begin
      if (timer_valid && elapsed < cfg_interval) return;
      dyaw   = (yaw > aim_yaw) ? yaw - aim_yaw : aim_yaw - yaw;
      dpitch = (pitch > aim_pitch) ? pitch - aim_pitch : aim_pitch - pitch;
      if (aim_valid && dyaw < int'(cfg_deadband) && dpitch < int'(cfg_deadband)) return;
      req.kind  = CMD_MOVE;
      req.yv    = tk.yaw;
      req.pitch = tk.pitch;
      req.pace  = cfg_pace;
      servo_due.push_back(req);
      aim_yaw     = yaw;
      aim_pitch   = pitch;
      aim_valid   = 1'b1;
      timer_ms    = tk.now_ms;
      timer_valid = 1'b1;
      return;
    end
    if (seq_mode >= NUM_MODES) return;
    pat = (seq_mode <= MODE_LAST_PAT) ? seq_mode : MODE_IDLE;
    case (pat)
      MODE_THINKING: begin ofs = 1;  len = 4; end
      MODE_REPLYING: begin ofs = 5;  len = 9; end
      MODE_ERROR:    begin ofs = 14; len = 7; end
      MODE_REMINDER: begin ofs = 21; len = 6; end
      default:       begin ofs = 0;  len = 1; end
    endcase
    if (seq_step >= len || seq_step >= MAX_STEPS) begin
      seq_step    = '0;
      timer_valid = 1'b0;
      return;
    end
    st = pattern_step(ofs + int'(seq_step));
    if (timer_valid && elapsed < st.dwell) return;
    if (st.spin) begin
      req.kind  = CMD_SPIN;
      req.yv    = st.x[11:0];
      req.pitch = '0;
      req.pace  = '0;
    end else begin
      p = int'(cfg_baseline) + st.dy;
      if (p < 0) p = 0;
      if (p > PITCH_CEIL) p = PITCH_CEIL;
      req.kind  = CMD_MOVE;
      req.yv    = st.x[11:0];
      req.pitch = p[9:0];
      req.pace  = st.pace[9:0];
    end
    servo_due.push_back(req);
    timer_ms    = tk.now_ms;
    timer_valid = 1'b1;
    seq_step    = seq_step + 6'd1;
  endfunction

  // Tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) compute_servo_request(tick_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tick_backlog.size() > 0) begin
          tick_on_bus = tick_backlog.pop_front();
          s_axis_tdata  <= {5'b0, tick_on_bus};
          s_axis_tvalid <= 1'b1;
          src_gap = src_steady ? 0 : $urandom_range(0, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Servo request monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (servo_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected request kind %0d value %0d pitch %0d pace %0d",
                     $time, got.kind, got.yv, got.pitch, got.pace);
          mismatches = mismatches + 1;
        end else begin
          want = servo_due.pop_front();
          if (got.kind != want.kind || got.yv != want.yv || got.pitch != want.pitch ||
              got.pace != want.pace) begin
            if (mismatches < 10)
              $display("%0t: expected kind %0d value %0d pitch %0d pace %0d, %s%0d %0d %0d %0d",
                       $time, want.kind, want.yv, want.pitch, want.pace, "got ",
                       got.kind, got.yv, got.pitch, got.pace);
            mismatches = mismatches + 1;
          end
        end
        sink_gap = sink_steady ? 0 : $urandom_range(0, 7);
      end
      if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic enqueue_tick(input logic [31:0] now, input logic [3:0] mode,
                              input logic trk, input int yaw, input int pitch);
    tick_t tk;
    tk.now_ms = now;
    tk.mode   = mode;
    tk.trk    = trk;
    tk.yaw    = yaw[11:0];
    tk.pitch  = pitch[9:0];
    tick_backlog.push_back(tk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CfgDataW-1:0];
  endtask

  task automatic program_regs(input int unsigned baseline, input int unsigned interval,
                              input int unsigned deadband, input int unsigned pace,
                              input int unsigned free_code);
    write_reg(CFG_PITCH_BASELINE, baseline);
    write_reg(CFG_TRACK_INTERVAL, interval);
    write_reg(CFG_TRACK_DEADBAND, deadband);
    write_reg(CFG_TRACK_PACE, pace);
    write_reg(CFG_FREE_MODE, free_code);
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    cfg_baseline  = baseline[9:0];
    cfg_interval  = interval[15:0];
    cfg_deadband  = deadband[9:0];
    cfg_pace      = pace[9:0];
    cfg_free_code = free_code[3:0];
    src_steady    = ($urandom_range(0, 3) == 0);
    sink_steady   = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly coherent runs of one mode and a drifting target, with noise
  task automatic queue_random(input int count);
    int r, band;
    if ($urandom_range(0, 2) == 0) gen_now = 32'hFFFF_FFFF - $urandom_range(0, 200000);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        gen_mode = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
      else if (r < 8)
        gen_mode = cfg_free_code;
      else if (r < 10)
        gen_mode = MODE_IDLE;
      if ($urandom_range(0, 99) < 5) gen_trk = !gen_trk;
      band = int'(cfg_deadband) + 2;
      case ($urandom_range(0, 9))
        0, 1: begin
          gen_yaw   = int'($urandom_range(0, 3600)) - 1800;
          gen_pitch = $urandom_range(0, 900);
        end
        2: begin
          gen_yaw   = int'($urandom_range(0, 4095)) - 2048;
          gen_pitch = $urandom_range(0, 1023);
        end
        default: begin
          gen_yaw   = gen_yaw + int'($urandom_range(0, 2 * band)) - band;
          gen_pitch = gen_pitch + int'($urandom_range(0, 2 * band)) - band;
          if (gen_yaw > 1800) gen_yaw = 1800;
          if (gen_yaw < -1800) gen_yaw = -1800;
          if (gen_pitch > 900) gen_pitch = 900;
          if (gen_pitch < 0) gen_pitch = 0;
        end
      endcase
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: gen_now = gen_now + $urandom_range(0, 400);
        5, 6, 7, 8:    gen_now = gen_now + $urandom_range(0, 1500);
        9, 10, 11:     gen_now = gen_now + $urandom_range(1000, 4000);
        12:            gen_now = gen_now + $urandom_range(0, 2 * int'(cfg_interval) + 1);
        13:            gen_now = gen_now;
        14:            gen_now = gen_now + $urandom_range(60000, 70000);
        default:       gen_now = $urandom();
      endcase
      enqueue_tick(gen_now, gen_mode, gen_trk, gen_yaw, gen_pitch);
    end
  endtask

  task automatic settle();
    while (tick_backlog.size() != 0 || s_axis_tvalid || servo_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    enqueue_tick(32'd0,         MODE_IDLE,      1'b0, 0,     0);
    enqueue_tick(32'd10,        MODE_IDLE,      1'b0, 0,     0);
    enqueue_tick(32'd20,        MODE_IDLE,      1'b0, 0,     0);
    enqueue_tick(32'd30,        MODE_REPLYING,  1'b0, 0,     0);
    enqueue_tick(32'd500,       MODE_REPLYING,  1'b0, 0,     0);
    enqueue_tick(32'd510,       MODE_REPLYING,  1'b0, 0,     0);
    enqueue_tick(32'd1510,      MODE_REPLYING,  1'b0, 0,     0);
    enqueue_tick(32'd1,         MODE_ERROR,     1'b0, 0,     0);
    enqueue_tick(32'hFFFF_FFF0, MODE_ERROR,     1'b0, 0,     0);
    enqueue_tick(32'h0000_00A4, MODE_ERROR,     1'b0, 0,     0);
    enqueue_tick(32'd0,         MODE_IDLE,      1'b1, 1800,  900);
    enqueue_tick(32'd50,        MODE_IDLE,      1'b1, -1800, 0);
    enqueue_tick(32'd100,       MODE_IDLE,      1'b1, -1800, 0);
    enqueue_tick(32'd300,       MODE_IDLE,      1'b1, -1781, 19);
    enqueue_tick(32'd400,       MODE_IDLE,      1'b1, -1780, 0);
    enqueue_tick(32'd500,       cfg_free_code,  1'b1, -2048, 1023);
    enqueue_tick(32'd510,       MODE_OTHER,     1'b1, 2047,  0);
    enqueue_tick(32'd520,       MODE_BEYOND,    1'b1, 0,     0);
    enqueue_tick(32'd530,       MODE_BEYOND,    1'b0, 0,     0);
    enqueue_tick(32'd540,       MODE_THINKING,  1'b0, 0,     0);
    enqueue_tick(32'd600,       MODE_REMINDER,  1'b1, 0,     0);
    enqueue_tick(32'd700,       MODE_OTHER_TOP, 1'b0, 0,     0);
    enqueue_tick(32'd710,       MODE_NO_PAT,    1'b0, 0,     0);
    settle();

    program_regs(900, 0, 0, 1000, 9);
    queue_random(150);
    settle();

    program_regs(0, 65535, 1023, 0, 0);
    queue_random(150);
    settle();

    repeat (5) begin
      program_regs($urandom_range(0, 900),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 400),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 64),
                   $urandom_range(0, 1000),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(10, 15)
                                               : $urandom_range(0, 9));
      queue_random(150);
      settle();
    end

    if (mismatches == 0 && servo_due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* servo_pattern_sequencer_top.f */
hdl/sps_pkg.sv
hdl/servo_pattern_sequencer_top.sv
tb/sv/servo_pattern_sequencer_top_tb.sv
